// File: design/sliding_median_threshold_alert_defines.svh
// Assertion macros for the sliding median threshold alert block.
// Used by the top level only; no other dependencies.
`ifndef SLIDING_MEDIAN_THRESHOLD_ALERT_DEFINES_SVH
`define SLIDING_MEDIAN_THRESHOLD_ALERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held.
`define SMTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is held.
`define SMTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMTA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SMTA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/smta_pkg.sv
// Shared types and constants for the sliding median threshold alert block.
// No dependencies.
package smta_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int CFG_W        = 9;
    localparam int DM_W         = 33;
    localparam int COUNT_W      = 32;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 72;
    localparam int OUT_TUSER_W  = 1;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(5);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DM_W-1:0]     t_dmedian;

    // Values broadcast to every cell of the sorted chain.
    typedef struct packed {
        t_sample sample;   // value that enters the window
        t_sample old;      // value that leaves the window
        logic    del_en;   // window full: a value leaves this step
    } t_cell_bcast;

    // Link from a cell to its left neighbor.
    typedef struct packed {
        t_sample val;      // stored value
        logic    gt_old;   // stored value lies past the removed copy
    } t_link_left;

    // Link from a cell to its right neighbor.
    typedef struct packed {
        t_sample u;        // value held here once the leaving copy is gone
        logic    b;        // that value sorts after the entering sample
    } t_link_right;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

// File: design/smta_cell.sv
// One cell of the sorted window chain: holds one value, removes and inserts.
// Depends on smta_pkg.
module smta_cell
    import smta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_upd,       // apply this step's remove and insert
    input  t_cell_bcast i_bcast,
    input  logic        i_in_cnt,    // this position holds a value after removal
    input  t_link_left  i_from_right,
    input  t_link_right i_from_left,
    output t_link_left  o_to_left,
    output t_link_right o_to_right
);

    t_sample r_val;
    t_sample n_val;
    t_sample u_val;
    logic    b_flag;

    always_comb begin
        // close the gap left by the removed copy
        u_val  = i_from_right.gt_old ? i_from_right.val : r_val;
        b_flag = !i_in_cnt || (u_val > i_bcast.sample);
        // open a gap for the entering sample
        if (b_flag) begin
            n_val = i_from_left.b ? i_from_left.u : i_bcast.sample;
        end else begin
            n_val = u_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_val <= n_val;
        end
    end

    assign o_to_left.val    = r_val;
    assign o_to_left.gt_old = i_bcast.del_en && (r_val > i_bcast.old);
    assign o_to_right.u     = u_val;
    assign o_to_right.b     = b_flag;

endmodule

// File: design/smta_ring.sv
// Arrival-order ring store: one write port, one read port, registered read.
// Depends on smta_pkg.
module smta_ring
    import smta_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_sample           i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_sample           o_rdata
);

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sliding_median_threshold_alert.sv
// Sliding-window median threshold alert, top level.
// Depends on smta_pkg, smta_cell, smta_ring and the assertion macro header.
//
// Use: each transfer on the s_axis channel carries one signed 32-bit sample.
// The block keeps the last window_size samples in a chain of sorted cells and
// in an arrival-order ring. Until the window is full a sample is only stored
// and its result reports window_full = 0. Once full, each result carries twice
// the median of the window before the sample, an alert when sample >= that
// value, and a saturating alert count; then the oldest sample leaves.
// Timing: a sample is taken in ST_IDLE (ring read of the oldest sample and
// median capture) and applied in ST_UPDATE, the state after it (remove,
// insert, compare), so the block takes no new sample until the last is applied;
// its result is loaded into the output register in ST_UPDATE and stays there until taken.
// A stalled receiver stops new input only while the output register is still
// full when the next sample arrives.
// Reset: window_size goes to 5, the window empties, the alert count clears.
// A cfg write (only while idle) sets window_size and empties the window but
// keeps the alert count; 0 acts as 1 and sizes past WINDOW_MAX saturate.

`include "sliding_median_threshold_alert_defines.svh"

module sliding_median_threshold_alert
    import smta_pkg::*;
#(
    parameter int WINDOW_MAX = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: window_size
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,     // [8:0] window_size
    // sample input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] sample
    // result output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [32:0] double_median, [33] alert,
                                                   // [65:34] alert_count, [71:66] zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] window_full
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int D_W   = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (D_W > CFG_W) ? D_W : CFG_W;
    localparam int PAD_W = OUT_TDATA_W - DM_W - 1 - COUNT_W;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_win_size;
    logic [D_W-1:0]      r_fill;
    logic [IDX_W-1:0]    r_ptr;
    logic [COUNT_W-1:0]  r_alerts;
    logic                r_full;
    logic                r_out_valid;

    // payload registers
    t_sample             r_sample;
    t_sample             r_med_lo;
    t_sample             r_med_hi;
    logic [OUT_TDATA_W-1:0] r_out_tdata;
    logic [OUT_TUSER_W-1:0] r_out_tuser;

    logic                in_xfer;
    logic                cfg_xfer;
    logic                upd;

    // effective window depth and median positions
    logic [CMP_W-1:0]    size_ext;
    logic [D_W-1:0]      depth;
    logic [D_W-1:0]      depth_m1;
    logic [IDX_W-1:0]    lo_idx;
    logic [IDX_W-1:0]    hi_idx;
    logic [D_W-1:0]      cnt;

    always_comb begin
        size_ext = CMP_W'(r_win_size);
        priority if (size_ext == '0) begin
            depth = D_W'(1);
        end else if (size_ext > CMP_W'(WINDOW_MAX)) begin
            depth = D_W'(WINDOW_MAX);
        end else begin
            depth = D_W'(size_ext);
        end
        depth_m1 = depth - D_W'(1);
        lo_idx   = IDX_W'(depth_m1 >> 1);
        hi_idx   = IDX_W'(depth >> 1);
        // values left in the chain after removal
        cnt      = r_full ? depth_m1 : r_fill;
    end

    // ---------------------------------------------------------------
    // Handshakes and sequencing
    // ---------------------------------------------------------------
    assign o_cfg_ready   = (r_state == ST_IDLE);
    assign cfg_xfer      = i_cfg_valid && o_cfg_ready;
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid
                           && (!r_out_valid || m_axis_tready);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign upd           = (r_state == ST_UPDATE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                n_state = in_xfer ? ST_UPDATE : ST_IDLE;
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sorted cell chain
    // ---------------------------------------------------------------
    t_cell_bcast bcast;
    t_sample     ring_rdata;
    t_link_left  to_left   [WINDOW_MAX];
    t_link_left  from_right[WINDOW_MAX];
    t_link_right to_right  [WINDOW_MAX];
    t_link_right from_left [WINDOW_MAX];
    logic        in_cnt    [WINDOW_MAX];

    assign bcast.sample = r_sample;
    assign bcast.old    = ring_rdata;
    assign bcast.del_en = r_full;

    for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
        assign in_cnt[gi] = D_W'(gi) < cnt;

        if (gi == 0) begin : g_left_edge
            assign from_left[gi] = '0;
        end else begin : g_left_link
            assign from_left[gi] = to_right[gi-1];
        end

        if (gi == WINDOW_MAX - 1) begin : g_right_edge
            assign from_right[gi] = '0;
        end else begin : g_right_link
            assign from_right[gi] = to_left[gi+1];
        end

        smta_cell u_cell (
            .i_clk        (i_clk),
            .i_upd        (upd),
            .i_bcast      (bcast),
            .i_in_cnt     (in_cnt[gi]),
            .i_from_right (from_right[gi]),
            .i_from_left  (from_left[gi]),
            .o_to_left    (to_left[gi]),
            .o_to_right   (to_right[gi])
        );
    end

    // Pick the two middle values out of the chain by position.
    t_sample med_lo;
    t_sample med_hi;

    always_comb begin
        med_lo = '0;
        med_hi = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            med_lo = med_lo | (to_left[i].val & {SAMPLE_W{lo_idx == IDX_W'(i)}});
            med_hi = med_hi | (to_left[i].val & {SAMPLE_W{hi_idx == IDX_W'(i)}});
        end
    end

    // ---------------------------------------------------------------
    // Arrival ring: read the oldest sample on transfer, write on update
    // ---------------------------------------------------------------
    logic [IDX_W-1:0] ring_waddr;

    assign ring_waddr = r_full ? r_ptr : r_fill[IDX_W-1:0];

    smta_ring #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (upd),
        .i_waddr (ring_waddr),
        .i_wdata (r_sample),
        .i_re    (in_xfer),
        .i_raddr (r_ptr),
        .o_rdata (ring_rdata)
    );

    // ---------------------------------------------------------------
    // Capture on transfer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sample <= t_sample'(s_axis_tdata);
            r_med_lo <= med_lo;
            r_med_hi <= med_hi;
        end
    end

    // ---------------------------------------------------------------
    // Compare and count on update
    // ---------------------------------------------------------------
    t_dmedian         dmed;
    t_dmedian         sample_ext;
    logic             alert;
    logic [COUNT_W-1:0] alerts_inc;
    logic [COUNT_W-1:0] n_alerts;

    always_comb begin
        dmed       = t_dmedian'(r_med_lo) + t_dmedian'(r_med_hi);
        sample_ext = t_dmedian'(r_sample);
        alert      = r_full && (sample_ext >= dmed);
        alerts_inc = (r_alerts == '1) ? r_alerts : r_alerts + COUNT_W'(1);
        n_alerts   = alert ? alerts_inc : r_alerts;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= CFG_RESET;
            r_fill     <= '0;
            r_ptr      <= '0;
            r_alerts   <= '0;
            r_full     <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                // new size: drop the whole window, keep the count
                r_win_size <= i_cfg_data;
                r_fill     <= '0;
                r_ptr      <= '0;
            end else if (upd) begin
                r_alerts <= n_alerts;
                if (r_full) begin
                    r_ptr <= (D_W'(r_ptr) == depth_m1) ? '0 : r_ptr + IDX_W'(1);
                end else begin
                    r_fill <= r_fill + D_W'(1);
                end
            end
            if (in_xfer) begin
                r_full <= (r_fill == depth);
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_out_tdata <= {{PAD_W{1'b0}}, n_alerts, alert,
                            (r_full ? dmed : t_dmedian'(0))};
            r_out_tuser <= OUT_TUSER_W'(r_full);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_tuser;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SMTA_ASSERT_NOW(a_fill_in_range, i_clk, i_rst_n, 1'b1, r_fill <= depth)
    `SMTA_ASSERT_NOW(a_ptr_in_range, i_clk, i_rst_n, 1'b1, D_W'(r_ptr) < depth)
    `SMTA_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, r_state == ST_UPDATE, !r_out_valid)
    `SMTA_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_xfer, r_state == ST_UPDATE)
    `SMTA_ASSERT_NOW(a_alert_needs_full, i_clk, i_rst_n,
                     m_axis_tvalid && m_axis_tdata[DM_W], m_axis_tuser[0])

endmodule

// File: dv/smta_result_checker.sv
// Result checker for the sliding median threshold alert block.
// Watches the cfg, sample and result channels, predicts each result and compares it.
// Depends on smta_pkg.
module smta_result_checker
    import smta_pkg::*;
#(
    parameter int WINDOW_MAX = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,      // [8:0] window_size
    input  logic                   i_sample_valid,
    input  logic                   i_sample_ready,
    input  logic [IN_TDATA_W-1:0]  i_sample_data,   // [31:0] sample
    input  logic                   i_result_valid,
    input  logic                   i_result_ready,
    input  logic [OUT_TDATA_W-1:0] i_result_data,   // [32:0] double_median, [33] alert,
                                                    // [65:34] alert_count
    input  logic [OUT_TUSER_W-1:0] i_result_user,   // [0] window_full
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_full_results,
    output int                     o_alerts
);

    typedef struct packed {
        logic                full;
        t_dmedian            dmed;
        logic                alert;
        logic [COUNT_W-1:0]  count;
    } t_alert_result;

    // Predicted window: sorted multiset plus arrival-order ring.
    t_sample            sorted_win [WINDOW_MAX];
    t_sample            arrival    [WINDOW_MAX];
    int unsigned        held;
    int unsigned        oldest;
    logic [CFG_W-1:0]   size_reg;
    logic [COUNT_W-1:0] alert_total;
    t_alert_result      expected_results [$];

    int mismatches;
    int full_seen;
    int alerts_seen;

    function automatic int unsigned window_depth();
        if (size_reg == '0) return 1;
        if (int'(size_reg) > WINDOW_MAX) return WINDOW_MAX;
        return int'(size_reg);
    endfunction

    // Insert into the first n sorted entries, n below the window depth.
    task automatic insert_sorted(input int unsigned n, input t_sample v);
        int unsigned i;
        i = n;
        while (i > 0 && sorted_win[i-1] > v) begin
            sorted_win[i] = sorted_win[i-1];
            i--;
        end
        sorted_win[i] = v;
    endtask

    task automatic predict_result(input t_sample s);
        int unsigned   depth;
        int unsigned   mid;
        int unsigned   pos;
        t_sample       leaving;
        t_alert_result r;
        depth = window_depth();
        r = '0;
        if (held < depth) begin
            // window still filling: store only
            arrival[(oldest + held) % depth] = s;
            insert_sorted(held, s);
            held++;
        end else begin
            mid = depth / 2;
            if (depth % 2 == 1)
                r.dmed = t_dmedian'(sorted_win[mid]) + t_dmedian'(sorted_win[mid]);
            else
                r.dmed = t_dmedian'(sorted_win[mid-1]) + t_dmedian'(sorted_win[mid]);
            r.full = 1'b1;
            if (t_dmedian'(s) >= r.dmed) begin
                r.alert = 1'b1;
                if (alert_total != '1) alert_total++;
            end
            // drop one copy of the oldest value, then insert the new one
            leaving = arrival[oldest];
            pos = depth - 1;
            for (int i = 0; i < depth; i++) begin
                if (sorted_win[i] == leaving) begin
                    pos = i;
                    break;
                end
            end
            for (int unsigned i = pos; i + 1 < depth; i++) sorted_win[i] = sorted_win[i+1];
            insert_sorted(depth - 1, s);
            arrival[oldest] = s;
            oldest = (oldest + 1) % depth;
        end
        r.count = alert_total;
        expected_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_alert_result want;
        t_alert_result got;
        if (!i_rst_n) begin
            size_reg    = CFG_RESET;
            held        = 0;
            oldest      = 0;
            alert_total = '0;
            mismatches  = 0;
            full_seen   = 0;
            alerts_seen = 0;
            expected_results.delete();
        end else begin
            if (i_result_valid && i_result_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    mismatches++;
                end else begin
                    want      = expected_results.pop_front();
                    got.full  = i_result_user[0];
                    got.dmed  = i_result_data[DM_W-1:0];
                    got.alert = i_result_data[DM_W];
                    got.count = i_result_data[DM_W+COUNT_W:DM_W+1];
                    if (got.full !== want.full) begin
                        $error("window_full mismatch: expected %0d, actual %0d",
                               want.full, got.full);
                        mismatches++;
                    end
                    if (got.dmed !== want.dmed) begin
                        $error("double_median mismatch: expected %0d, actual %0d",
                               want.dmed, got.dmed);
                        mismatches++;
                    end
                    if (got.alert !== want.alert) begin
                        $error("alert mismatch: expected %0d, actual %0d",
                               want.alert, got.alert);
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $error("alert_count mismatch: expected %0d, actual %0d",
                               want.count, got.count);
                        mismatches++;
                    end
                    full_seen   += want.full;
                    alerts_seen += want.alert;
                end
            end
            // a size write empties the window but keeps the alert count
            if (i_cfg_valid && i_cfg_ready) begin
                size_reg = i_cfg_data;
                held     = 0;
                oldest   = 0;
            end
            if (i_sample_valid && i_sample_ready) predict_result(t_sample'(i_sample_data));
        end
        o_fail_count   <= mismatches;
        o_pending      <= expected_results.size();
        o_full_results <= full_seen;
        o_alerts       <= alerts_seen;
    end

endmodule

// File: dv/tb_sliding_median_threshold_alert.sv
// Testbench top for the sliding median threshold alert block.
// Drives samples and window_size writes, throttles the result channel and gives the verdict.
// Depends on smta_pkg, the block's RTL and smta_result_checker.
module tb_sliding_median_threshold_alert;
    import smta_pkg::*;

    localparam int      WIN_MAX        = 256;
    localparam int      RESET_CYCLES   = 6;
    localparam int      DRAIN_CYCLES   = 6;
    localparam int      LONG_HOLD      = 64;
    localparam int      WATCHDOG_LIMIT = 2000;
    localparam t_sample SMPL_MIN       = 32'sh8000_0000;
    localparam t_sample SMPL_MAX       = 32'sh7FFF_FFFF;

    typedef enum int {
        RX_FREE,      // always ready
        RX_COIN,      // ready half the time
        RX_SPARSE,    // ready one cycle in four
        RX_TOGGLE     // ready every other cycle
    } t_stall_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data = CFG_RESET;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // set once by the stimulus to ask the receiver for its long hold
    logic hold_req = 1'b0;

    int fail_count;
    int pending_results;
    int full_results;
    int alerts_total;
    int samples_sent = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    sliding_median_threshold_alert #(
        .WINDOW_MAX (WIN_MAX)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    smta_result_checker #(
        .WINDOW_MAX (WIN_MAX)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_sample_valid (s_axis_tvalid),
        .i_sample_ready (s_axis_tready),
        .i_sample_data  (s_axis_tdata),
        .i_result_valid (m_axis_tvalid),
        .i_result_ready (m_axis_tready),
        .i_result_data  (m_axis_tdata),
        .i_result_user  (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_full_results (full_results),
        .o_alerts       (alerts_total)
    );

    // Pick the next random sample. The mix keeps alerts and non-alerts both
    // common: full-range values exercise every bit, small values cluster
    // around the median, repeats build equal copies in the window and
    // doubled values land near the alert threshold.
    function automatic t_sample next_sample(input t_sample prev);
        t_sample v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4, 5, 6: begin
                v = $urandom_range(0, 200);
                v = v - 100;
            end
            7: begin
                if ($urandom_range(0, 1) == 1) v = SMPL_MAX - $urandom_range(0, 3);
                else v = SMPL_MIN + $urandom_range(0, 3);
            end
            8: v = prev;
            default: v = prev <<< 1;
        endcase
        return v;
    endfunction

    // Offer one sample and hold it until the transfer happens.
    task automatic send_sample(input t_sample s);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
    endtask

    // Stream a batch in bursts. Valid stays high across a burst; between
    // bursts it is dropped and held low before the next burst, so it is never
    // lowered and raised in the same step. Long bursts give stretches with no gaps.
    task automatic stream_samples(input t_sample batch[$]);
        int burst_left;
        burst_left = $urandom_range(1, 12);
        foreach (batch[n]) begin
            send_sample(batch[n]);
            burst_left--;
            if (burst_left == 0 || n == batch.size() - 1) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
            end
        end
    endtask

    // Write window_size only while the block is idle: every expected
    // result has arrived and the pipeline has had time to drain.
    task automatic write_window_size(input logic [CFG_W-1:0] sz);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sz;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Main stimulus.
    initial begin
        t_sample batch[$];
        t_sample prev;
        int      phase_size[$];
        int      phase_len[$];
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size of 5: field extremes fill the window, then an extreme
        // alert and non-alert, then equal copies and a sample exactly at
        // twice the median followed by one just below it.
        batch = '{SMPL_MIN, SMPL_MAX, 0, -1, 1, SMPL_MAX, SMPL_MIN,
                  7, 7, 7, 7, 7, 14, 13};
        stream_samples(batch);

        // Size zero acts as one: the median is the previous sample.
        write_window_size('0);
        batch = '{-3, -6, 0, 0, 1};
        stream_samples(batch);

        // Even size with both extremes: largest and smallest double median.
        write_window_size(CFG_W'(2));
        batch = '{SMPL_MAX, SMPL_MAX, SMPL_MAX, SMPL_MIN, SMPL_MIN, SMPL_MIN};
        stream_samples(batch);

        // Random phases. The top write value saturates to the full depth;
        // most phases keep the window small so it fills quickly.
        phase_size = '{1, 2, 3, 4, 511, 256, 7, 8, 0};
        phase_len  = '{60, 60, 60, 50, 300, 20, 60, 60, 60};
        phase_size[8] = $urandom_range(9, 40);
        prev = '0;
        foreach (phase_size[p]) begin
            write_window_size(CFG_W'(phase_size[p]));
            // ask for the long receiver hold while samples keep coming
            if (p == 2) hold_req <= 1'b1;
            batch.delete();
            repeat (phase_len[p]) begin
                prev = next_sample(prev);
                batch.push_back(prev);
            end
            stream_samples(batch);
        end

        // Wait for the last results, then let the pipeline settle.
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d samples across %0d window_size writes (sizes 0..511).",
                 samples_sent, cfg_writes);
        $display("Checked %0d full-window results, %0d of them alerts.",
                 full_results, alerts_total);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Receiver: stall on a randomly chosen pattern that changes over the run.
    // Once asked, hold off for a long stretch so the output register stays
    // full and the block has to stop taking samples.
    initial begin
        t_stall_mode mode;
        int          span;
        bit          hold_done;
        mode      = RX_FREE;
        span      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            if (span == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                span = $urandom_range(20, 80);
            end
            span--;
            case (mode)
                RX_FREE:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // Watchdog: end the run if no channel moves a transfer for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
